// ===== rtl/core/rrw_pkg.sv =====
// Shared constants, codes and stage-to-stage structs of the robust residual weight block.
`timescale 1ns / 1ps

package rrw_pkg;

    // Field and datapath widths.
    localparam int RES_W  = 32;           // residual, signed Q16.16
    localparam int FRAC_W = 16;           // fraction bits of Q16.16 and Q1.16
    localparam int U_W    = 32;           // scaled magnitude u, unsigned Q16.16
    localparam int W_W    = 17;           // weight, unsigned Q1.16
    localparam int C_W    = 19;           // bits of u below the bisquare cutoff
    localparam int SQ_W   = 2 * C_W;      // u squared, also the second divider remainder
    localparam int DATA_W = 32;           // configuration data
    localparam int ADDR_W = 3;            // byte address of two 32-bit registers

    // Tuning constants in fixed point.
    localparam logic [U_W-1:0]  HUBER_K = 32'd88146;          // 1.345 in Q16.16
    localparam logic [U_W-1:0]  BISQ_C  = 32'd307036;         // 4.685 in Q16.16
    localparam logic [SQ_W-1:0] BISQ_C2 = 38'd94271105296;    // BISQ_C squared
    localparam logic [W_W-1:0]  ONE_Q16 = 17'd65536;          // 1.0 in Q1.16

    typedef enum logic {
        MODE_HUBER = 1'b0,
        MODE_TUKEY = 1'b1
    } t_mode;

    typedef enum logic {
        REG_SIGMA = 1'b0,
        REG_MODE  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [U_W-1:0] sigma;
        t_mode          mode;
    } t_cfg;

    // Result of the ratio divider, already saturated.
    typedef struct packed {
        logic           valid;
        logic [U_W-1:0] u;
    } t_ratio;

    // Result of the weight divider with the range flags of u.
    typedef struct packed {
        logic              valid;
        logic              le_k;    // u at or below the Huber knee
        logic              ge_c;    // u at or beyond the bisquare cutoff
        logic [FRAC_W-1:0] quo;
    } t_wq;

endpackage

// ===== rtl/core/rrw_if.sv =====
// Valid/ready channel interfaces for residual items and weight items.
`timescale 1ns / 1ps

interface rrw_res_if;
    logic                           valid;
    logic                           ready;
    logic signed [rrw_pkg::RES_W-1:0] residual;

    modport source (output valid, output residual, input ready);
    modport sink   (input valid, input residual, output ready);
endinterface

interface rrw_wgt_if;
    logic                     valid;
    logic                     ready;
    logic [rrw_pkg::W_W-1:0]  weight;

    modport source (output valid, output weight, input ready);
    modport sink   (input valid, input weight, output ready);
endinterface

// ===== rtl/core/rrw_ratio_div.sv =====
// Pipelined restoring divider that forms u = |residual| / sigma with saturation.
`timescale 1ns / 1ps

module rrw_ratio_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [rrw_pkg::RES_W-1:0]   i_residual,
    input  rrw_pkg::t_cfg               i_cfg,
    output rrw_pkg::t_ratio             o_ratio
);

    localparam int STEPS = rrw_pkg::U_W;
    localparam int UW    = rrw_pkg::U_W;
    localparam int LO_W  = rrw_pkg::FRAC_W;
    localparam int HI_W  = rrw_pkg::RES_W - LO_W;

    logic                        r_v0;
    logic [rrw_pkg::RES_W-1:0]   r_mag;
    logic [rrw_pkg::RES_W-1:0]   n_mag;

    logic            r_v   [0:STEPS];
    logic            r_sat [0:STEPS];
    logic [UW-1:0]   r_rem [0:STEPS];
    logic [UW-1:0]   r_quo [0:STEPS];
    logic [LO_W-1:0] r_dvd [0:STEPS];
    logic            n_v   [0:STEPS];
    logic            n_sat [0:STEPS];
    logic [UW-1:0]   n_rem [0:STEPS];
    logic [UW-1:0]   n_quo [0:STEPS];
    logic [LO_W-1:0] n_dvd [0:STEPS];

    // The most negative residual negates onto itself, which is 2^31 unsigned.
    assign n_mag = i_residual[rrw_pkg::RES_W-1] ? (~i_residual + 1'b1) : i_residual;

    always_comb begin
        logic [UW:0] rs;
        logic [UW:0] dv;
        logic [UW:0] diff;
        dv = {1'b0, i_cfg.sigma};
        // The quotient overflows 32 bits exactly when mag >= sigma * 2^16.
        n_v[0]   = r_v0;
        n_sat[0] = {{LO_W{1'b0}}, r_mag} >= {i_cfg.sigma, {LO_W{1'b0}}};
        n_rem[0] = {{(UW - HI_W){1'b0}}, r_mag[rrw_pkg::RES_W-1:LO_W]};
        n_quo[0] = '0;
        n_dvd[0] = r_mag[LO_W-1:0];
        for (int k = 1; k <= STEPS; k++) begin
            rs       = {r_rem[k-1], r_dvd[k-1][LO_W-1]};
            diff     = rs - dv;
            n_v[k]   = r_v[k-1];
            n_sat[k] = r_sat[k-1];
            n_dvd[k] = {r_dvd[k-1][LO_W-2:0], 1'b0};
            if (rs >= dv) begin
                n_rem[k] = diff[UW-1:0];
                n_quo[k] = {r_quo[k-1][UW-2:0], 1'b1};
            end else begin
                n_rem[k] = rs[UW-1:0];
                n_quo[k] = {r_quo[k-1][UW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v  <= '{default: 1'b0};
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v  <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
            r_sat <= n_sat;
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_dvd <= n_dvd;
        end
    end

    always_comb begin
        o_ratio.valid = r_v[STEPS];
        o_ratio.u     = r_sat[STEPS] ? '1 : r_quo[STEPS];
    end

endmodule

// ===== rtl/core/rrw_weight_div.sv =====
// Pipelined divider shared by both modes: K/u for Huber, u^2/C^2 for bisquare.
`timescale 1ns / 1ps

module rrw_weight_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  rrw_pkg::t_ratio   i_ratio,
    input  rrw_pkg::t_cfg     i_cfg,
    output rrw_pkg::t_wq      o_wq
);

    localparam int STEPS = rrw_pkg::FRAC_W;
    localparam int RW    = rrw_pkg::SQ_W;
    localparam int UW    = rrw_pkg::U_W;
    localparam int CW    = rrw_pkg::C_W;

    logic            r_v    [0:STEPS];
    logic            r_le_k [0:STEPS];
    logic            r_ge_c [0:STEPS];
    logic [UW-1:0]   r_u    [0:STEPS];
    logic [RW-1:0]   r_rem  [0:STEPS];
    logic [STEPS-1:0] r_quo [0:STEPS];
    logic            n_v    [0:STEPS];
    logic            n_le_k [0:STEPS];
    logic            n_ge_c [0:STEPS];
    logic [UW-1:0]   n_u    [0:STEPS];
    logic [RW-1:0]   n_rem  [0:STEPS];
    logic [STEPS-1:0] n_quo [0:STEPS];

    always_comb begin
        logic [RW:0] rs;
        logic [RW:0] dv;
        logic [RW:0] diff;
        // Entry stage: the square of u is the bisquare dividend, the knee the Huber one.
        n_v[0]    = i_ratio.valid;
        n_le_k[0] = i_ratio.u <= rrw_pkg::HUBER_K;
        n_ge_c[0] = i_ratio.u >= rrw_pkg::BISQ_C;
        n_u[0]    = i_ratio.u;
        n_quo[0]  = '0;
        if (i_cfg.mode == rrw_pkg::MODE_TUKEY) begin
            n_rem[0] = i_ratio.u[CW-1:0] * i_ratio.u[CW-1:0];
        end else begin
            n_rem[0] = {{(RW - UW){1'b0}}, rrw_pkg::HUBER_K};
        end
        // Both dividends carry sixteen zero bits below the initial remainder.
        for (int k = 1; k <= STEPS; k++) begin
            if (i_cfg.mode == rrw_pkg::MODE_TUKEY) begin
                dv = {1'b0, rrw_pkg::BISQ_C2};
            end else begin
                dv = {{(RW - UW + 1){1'b0}}, r_u[k-1]};
            end
            rs        = {r_rem[k-1], 1'b0};
            diff      = rs - dv;
            n_v[k]    = r_v[k-1];
            n_le_k[k] = r_le_k[k-1];
            n_ge_c[k] = r_ge_c[k-1];
            n_u[k]    = r_u[k-1];
            if (rs >= dv) begin
                n_rem[k] = diff[RW-1:0];
                n_quo[k] = {r_quo[k-1][STEPS-2:0], 1'b1};
            end else begin
                n_rem[k] = rs[RW-1:0];
                n_quo[k] = {r_quo[k-1][STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '{default: 1'b0};
        end else if (i_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_le_k <= n_le_k;
            r_ge_c <= n_ge_c;
            r_u    <= n_u;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
        end
    end

    always_comb begin
        o_wq.valid = r_v[STEPS];
        o_wq.le_k  = r_le_k[STEPS];
        o_wq.ge_c  = r_ge_c[STEPS];
        o_wq.quo   = r_quo[STEPS];
    end

endmodule

// ===== rtl/core/rrw_weight_out.sv =====
// Final stage: bisquare squaring and selection of the weight by sigma, mode and range.
`timescale 1ns / 1ps

module rrw_weight_out (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  rrw_pkg::t_wq             i_wq,
    input  rrw_pkg::t_cfg            i_cfg,
    output logic                     o_valid,
    output logic [rrw_pkg::W_W-1:0]  o_weight
);

    localparam int WW = rrw_pkg::W_W;
    localparam int FW = rrw_pkg::FRAC_W;

    logic                r_v;
    logic                r_le_k;
    logic                r_ge_c;
    logic [FW-1:0]       r_quo;
    logic [2*WW-1:0]     r_sq;
    logic [WW-1:0]       n_t;

    // One minus (u/C)^2, which stays in 1..65536.
    assign n_t = rrw_pkg::ONE_Q16 - {1'b0, i_wq.quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_wq.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_le_k <= i_wq.le_k;
            r_ge_c <= i_wq.ge_c;
            r_quo  <= i_wq.quo;
            r_sq   <= n_t * n_t;
        end
    end

    assign o_valid = r_v;

    always_comb begin
        if (i_cfg.sigma == '0) begin
            o_weight = rrw_pkg::ONE_Q16;
        end else if (i_cfg.mode == rrw_pkg::MODE_HUBER) begin
            o_weight = r_le_k ? rrw_pkg::ONE_Q16 : {1'b0, r_quo};
        end else begin
            o_weight = r_ge_c ? '0 : r_sq[FW+WW-1:FW];
        end
    end

endmodule

// ===== rtl/core/robust_residual_weight.sv =====
// Top level of the robust residual weight block with its register port and output buffer.
`timescale 1ns / 1ps

// Robust IRLS weight unit. Each residual item (signed Q16.16) yields one weight item
// (unsigned Q1.16, 65536 = 1.0). The block forms u = |residual| / sigma_scale in Q16.16,
// truncated and saturated to 32 bits, then gives Huber weights (1 up to u = 1.345, else
// 1.345/u) or Tukey bisquare weights (zero from u = 4.685 on, else (1-(u/4.685)^2)^2),
// chosen by weight_mode; a sigma_scale of zero makes every weight 1. The block takes one
// item every clock cycle while its skid entry is empty. The pipeline consists of the two
// one-bit-per-stage restoring dividers, 34 stages for the 32-bit ratio (magnitude, setup and
// 32 quotient steps) and 17 for the 16-bit weight quotient, then one squaring stage and the
// output register. Registers: sigma_scale at byte address 0 (reset 1.0) and weight_mode at
// address 4 (reset Huber). Write them only while no item is in flight.
module robust_residual_weight (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rrw_res_if.sink                        i_res,
    rrw_wgt_if.source                      o_wgt,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rrw_pkg::ADDR_W-1:0]     paddr,
    input  logic [rrw_pkg::DATA_W-1:0]     pwdata,
    output logic [rrw_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    localparam int WW = rrw_pkg::W_W;
    localparam int DW = rrw_pkg::DATA_W;
    localparam int AW = rrw_pkg::ADDR_W;

    // Configuration registers.
    logic [rrw_pkg::U_W-1:0] r_sigma;
    rrw_pkg::t_mode          r_mode;
    rrw_pkg::t_cfg           cfg;
    rrw_pkg::t_reg_idx       reg_idx;
    logic                    cfg_wr;

    // Pipeline links.
    logic             en;
    rrw_pkg::t_ratio  ratio;
    rrw_pkg::t_wq     wq;
    logic             pipe_v;
    logic [WW-1:0]    pipe_w;
    logic             take;

    // Output register plus one skid entry.
    logic             r_out_v;
    logic [WW-1:0]    r_out_w;
    logic             r_skid_v;
    logic [WW-1:0]    r_skid_w;
    logic             out_take;

    // The register index is the word address; every address lands on a register.
    assign reg_idx = rrw_pkg::t_reg_idx'(paddr[AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= 32'd65536;
            r_mode  <= rrw_pkg::MODE_HUBER;
        end else if (cfg_wr) begin
            case (reg_idx)
                rrw_pkg::REG_SIGMA: r_sigma <= pwdata;
                rrw_pkg::REG_MODE:  r_mode  <= rrw_pkg::t_mode'(pwdata[0]);
                default:            r_sigma <= r_sigma;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rrw_pkg::REG_SIGMA: prdata = r_sigma;
            rrw_pkg::REG_MODE:  prdata = {{(DW - 1){1'b0}}, r_mode};
            default:            prdata = '0;
        endcase
    end

    assign cfg.sigma = r_sigma;
    assign cfg.mode  = r_mode;

    // The whole pipeline advances together. It freezes only when the skid entry is
    // occupied, which depends on registers alone, so the downstream ready never reaches
    // the input ready combinationally. A frozen pipeline still holds its last item,
    // which is taken once the skid entry drains.
    assign en          = !r_skid_v;
    assign i_res.ready = en;

    rrw_ratio_div u_ratio (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_res.valid),
        .i_residual (i_res.residual),
        .i_cfg      (cfg),
        .o_ratio    (ratio)
    );

    rrw_weight_div u_wdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ratio (ratio),
        .i_cfg   (cfg),
        .o_wq    (wq)
    );

    rrw_weight_out u_wout (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_wq     (wq),
        .i_cfg    (cfg),
        .o_valid  (pipe_v),
        .o_weight (pipe_w)
    );

    // An item leaves the pipeline only on a cycle in which the pipeline moves.
    assign take     = pipe_v && en;
    assign out_take = r_out_v && o_wgt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (take) begin
            if (r_out_v && !out_take) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (out_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_take) begin
                r_out_w <= r_skid_w;
            end
        end else if (take) begin
            if (r_out_v && !out_take) begin
                r_skid_w <= pipe_w;
            end else begin
                r_out_w <= pipe_w;
            end
        end
    end

    assign o_wgt.valid  = r_out_v;
    assign o_wgt.weight = r_out_w;

    // The skid entry is only ever filled behind a waiting output item.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry holds an item while the output register is empty");

    // The skid entry fills only when the output item was stalled in the cycle before.
    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_wgt.ready))
        else $error("skid entry filled while the output was not stalled");

    // A frozen pipeline keeps its last item in place.
    a_frozen_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(pipe_v))
        else $error("pipeline output moved while the pipeline was frozen");

    // Weights never exceed 1.0.
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_w <= rrw_pkg::ONE_Q16))
        else $error("weight above 1.0");

endmodule
